// File: rtl/spm_pkg.sv
package spm_pkg;

  localparam int unsigned MAX_TERMS = 32;
  localparam int unsigned IDX_W     = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int unsigned CNT_W     = $clog2(MAX_TERMS + 1);

  localparam int unsigned COEFF_W   = 32;
  localparam int unsigned EXP_W     = 16;
  localparam int unsigned SUM_W     = COEFF_W + 1;

  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 56;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_READ,
    ST_PICK
  } state_e;

  typedef struct packed {
    logic signed [COEFF_W-1:0] coeff;
    logic signed [EXP_W-1:0]   exp;
  } term_t;

  // outcome of one head comparison
  typedef struct packed {
    logic                    take_a;
    logic                    take_b;
    logic signed [SUM_W-1:0] coeff;
    logic signed [EXP_W-1:0] exp;
  } pick_t;

endpackage

// File: rtl/spm_store.sv
module spm_store (
  input  logic                      clk_i,
  input  logic                      wr_en_i,
  input  logic                      wr_sel_i,
  input  logic [spm_pkg::IDX_W-1:0] wr_idx_i,
  input  spm_pkg::term_t            wr_term_i,
  input  logic [spm_pkg::IDX_W-1:0] rd_idx_a_i,
  input  logic [spm_pkg::IDX_W-1:0] rd_idx_b_i,
  output spm_pkg::term_t            rd_term_a_o,
  output spm_pkg::term_t            rd_term_b_o
);

  spm_pkg::term_t mem_a [spm_pkg::MAX_TERMS];
  spm_pkg::term_t mem_b [spm_pkg::MAX_TERMS];

  always_ff @(posedge clk_i) begin
    if (wr_en_i && !wr_sel_i) begin
      mem_a[wr_idx_i] <= wr_term_i;
    end
    rd_term_a_o <= mem_a[rd_idx_a_i];
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i && wr_sel_i) begin
      mem_b[wr_idx_i] <= wr_term_i;
    end
    rd_term_b_o <= mem_b[rd_idx_b_i];
  end

endmodule

// File: rtl/spm_pick.sv
module spm_pick (
  input  logic           live_a_i,
  input  logic           live_b_i,
  input  spm_pkg::term_t head_a_i,
  input  spm_pkg::term_t head_b_i,
  output spm_pkg::pick_t pick_o
);

  logic                            a_gt;
  logic                            b_gt;
  logic signed [spm_pkg::SUM_W-1:0] ext_a;
  logic signed [spm_pkg::SUM_W-1:0] ext_b;

  always_comb begin
    a_gt  = head_a_i.exp > head_b_i.exp;
    b_gt  = head_b_i.exp > head_a_i.exp;
    ext_a = spm_pkg::SUM_W'(head_a_i.coeff);
    ext_b = spm_pkg::SUM_W'(head_b_i.coeff);

    pick_o.take_a = live_a_i && (!live_b_i || !b_gt);
    pick_o.take_b = live_b_i && (!live_a_i || !a_gt);

    // equal heads take both and add
    pick_o.coeff = (pick_o.take_a ? ext_a : '0) + (pick_o.take_b ? ext_b : '0);
    pick_o.exp   = pick_o.take_a ? head_a_i.exp : head_b_i.exp;
  end

endmodule

// File: rtl/sparse_polynomial_merge_add.sv
// Sparse polynomial merge-add.
// Terms come in on the s_axis channel, one item per cycle while s_axis_tready
// is high: tuser picks the list (0 first, 1 second), tlast marks a list's end.
// Each list holds up to 32 terms; further terms are dropped and flagged.
// The item with tuser and tlast both high starts the merge; tready stays low
// until the final merged item has been handed to the output register.
// Merged terms leave on m_axis in descending exponent order when each list
// came in that order, equal exponents summed, with tlast on the last one and
// tuser set on every item of a merge if any term was dropped during its load.
// Each result passes through a memory read state (ST_READ), then a compare
// and add state (ST_PICK) in the shared pick unit, which loads the output
// register; a further read starts only after that load.
// A stalled receiver holds the output register and the sequencer waits on it.
// Reset empties both lists and clears the drop flag; stored terms are not
// cleared and are only read below the counts.
module sparse_polynomial_merge_add (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // in_coeff[31:0], in_exponent[47:32]
  input  logic        s_axis_tuser,  // which_poly
  input  logic        s_axis_tlast,  // last_term
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,  // out_coeff[32:0], out_exponent[48:33], zeros
  output logic        m_axis_tuser,  // overflow
  output logic        m_axis_tlast   // final_term
);

  spm_pkg::state_e state_q, state_d;

  logic [spm_pkg::CNT_W-1:0] cnt_a_q, cnt_a_d;
  logic [spm_pkg::CNT_W-1:0] cnt_b_q, cnt_b_d;
  logic [spm_pkg::CNT_W-1:0] idx_a_q, idx_a_d;
  logic [spm_pkg::CNT_W-1:0] idx_b_q, idx_b_d;
  logic                      dropped_q, dropped_d;

  logic                               out_valid_q, out_valid_d;
  logic signed [spm_pkg::SUM_W-1:0]   out_coeff_q;
  logic signed [spm_pkg::EXP_W-1:0]   out_exp_q;
  logic                               out_last_q;
  logic                               out_ovf_q;

  logic                      in_fire;
  logic                      full_a;
  logic                      full_b;
  logic                      wr_en;
  logic [spm_pkg::IDX_W-1:0] wr_idx;
  spm_pkg::term_t            wr_term;
  spm_pkg::term_t            head_a;
  spm_pkg::term_t            head_b;
  spm_pkg::pick_t            pick;
  logic                      live_a;
  logic                      live_b;
  logic [spm_pkg::CNT_W-1:0] nxt_a;
  logic [spm_pkg::CNT_W-1:0] nxt_b;
  logic                      is_final;
  logic                      out_load;
  logic                      merge_go;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign merge_go = in_fire && s_axis_tuser && s_axis_tlast;
  assign full_a   = cnt_a_q == spm_pkg::CNT_W'(spm_pkg::MAX_TERMS);
  assign full_b   = cnt_b_q == spm_pkg::CNT_W'(spm_pkg::MAX_TERMS);
  assign wr_en    = in_fire && (s_axis_tuser ? !full_b : !full_a);
  assign wr_idx   = s_axis_tuser ? cnt_b_q[spm_pkg::IDX_W-1:0]
                                 : cnt_a_q[spm_pkg::IDX_W-1:0];
  assign wr_term.coeff = s_axis_tdata[31:0];
  assign wr_term.exp   = s_axis_tdata[47:32];

  spm_store u_store (
    .clk_i       (clk_i),
    .wr_en_i     (wr_en),
    .wr_sel_i    (s_axis_tuser),
    .wr_idx_i    (wr_idx),
    .wr_term_i   (wr_term),
    .rd_idx_a_i  (idx_a_q[spm_pkg::IDX_W-1:0]),
    .rd_idx_b_i  (idx_b_q[spm_pkg::IDX_W-1:0]),
    .rd_term_a_o (head_a),
    .rd_term_b_o (head_b)
  );

  assign live_a = idx_a_q < cnt_a_q;
  assign live_b = idx_b_q < cnt_b_q;

  spm_pick u_pick (
    .live_a_i (live_a),
    .live_b_i (live_b),
    .head_a_i (head_a),
    .head_b_i (head_b),
    .pick_o   (pick)
  );

  assign nxt_a    = idx_a_q + spm_pkg::CNT_W'(pick.take_a);
  assign nxt_b    = idx_b_q + spm_pkg::CNT_W'(pick.take_b);
  assign is_final = (nxt_a >= cnt_a_q) && (nxt_b >= cnt_b_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      spm_pkg::ST_LOAD: begin
        if (merge_go) state_d = spm_pkg::ST_READ;
      end
      spm_pkg::ST_READ: begin
        state_d = spm_pkg::ST_PICK;
      end
      spm_pkg::ST_PICK: begin
        if (out_load) state_d = is_final ? spm_pkg::ST_LOAD : spm_pkg::ST_READ;
      end
      default: state_d = spm_pkg::ST_LOAD;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_axis_tready = 1'b0;
    out_load      = 1'b0;
    case (state_q)
      spm_pkg::ST_LOAD: s_axis_tready = 1'b1;
      spm_pkg::ST_READ: ;
      spm_pkg::ST_PICK: out_load = !out_valid_q || m_axis_tready;
      default: ;
    endcase
  end

  always_comb begin
    cnt_a_d   = cnt_a_q;
    cnt_b_d   = cnt_b_q;
    idx_a_d   = idx_a_q;
    idx_b_d   = idx_b_q;
    dropped_d = dropped_q;
    if (in_fire) begin
      if (s_axis_tuser) begin
        if (full_b) dropped_d = 1'b1;
        else        cnt_b_d   = cnt_b_q + spm_pkg::CNT_W'(1);
      end else begin
        if (full_a) dropped_d = 1'b1;
        else        cnt_a_d   = cnt_a_q + spm_pkg::CNT_W'(1);
      end
    end
    if (out_load) begin
      if (is_final) begin
        cnt_a_d   = '0;
        cnt_b_d   = '0;
        idx_a_d   = '0;
        idx_b_d   = '0;
        dropped_d = 1'b0;
      end else begin
        idx_a_d = nxt_a;
        idx_b_d = nxt_b;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready) out_valid_d = 1'b0;
    if (out_load)      out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= spm_pkg::ST_LOAD;
      cnt_a_q     <= '0;
      cnt_b_q     <= '0;
      idx_a_q     <= '0;
      idx_b_q     <= '0;
      dropped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_a_q     <= cnt_a_d;
      cnt_b_q     <= cnt_b_d;
      idx_a_q     <= idx_a_d;
      idx_b_q     <= idx_b_d;
      dropped_q   <= dropped_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_coeff_q <= pick.coeff;
      out_exp_q   <= pick.exp;
      out_last_q  <= is_final;
      out_ovf_q   <= dropped_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_exp_q, out_coeff_q};
  assign m_axis_tuser  = out_ovf_q;
  assign m_axis_tlast  = out_last_q;

endmodule

// File: test/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // one merged term as it should leave the block
  typedef struct {
    logic signed [spm_pkg::SUM_W-1:0] coeff;
    logic signed [spm_pkg::EXP_W-1:0] exp;
    logic                             final_term;
    logic                             dropped;
  } merged_term_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;   // in_coeff[31:0], in_exponent[47:32]
  logic        s_axis_tuser;   // which_poly
  logic        s_axis_tlast;   // last_term
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [55:0] m_axis_tdata;   // out_coeff[32:0], out_exponent[48:33], zeros
  logic        m_axis_tuser;   // overflow
  logic        m_axis_tlast;   // final_term

  sparse_polynomial_merge_add dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // predicted contents of the two term lists
  spm_pkg::term_t first_terms [spm_pkg::MAX_TERMS];
  spm_pkg::term_t second_terms[spm_pkg::MAX_TERMS];
  int unsigned    first_len;
  int unsigned    second_len;
  bit             drop_seen;
  merged_term_t   expected_terms[$];

  int unsigned  items_sent;
  int unsigned  terms_loaded;
  int unsigned  merges_seen;
  int unsigned  overflow_merges;
  int unsigned  terms_checked;
  int unsigned  errors;
  bit           calm;   // no idling on either side while set

  always #5 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(99) >= 7);
  end

  // stores one loaded term; the closing term of the second list merges both
  function automatic void load_term(logic which, spm_pkg::term_t t, logic last);
    int unsigned                      i;
    int unsigned                      j;
    logic signed [spm_pkg::EXP_W-1:0] ea;
    logic signed [spm_pkg::EXP_W-1:0] eb;
    logic signed [spm_pkg::SUM_W-1:0] ca;
    logic signed [spm_pkg::SUM_W-1:0] cb;
    merged_term_t                     m;
    i = 0;
    j = 0;
    if (!which) begin
      if (first_len < spm_pkg::MAX_TERMS) begin
        first_terms[first_len] = t;
        first_len++;
      end else begin
        drop_seen = 1'b1;
      end
      return;
    end
    if (second_len < spm_pkg::MAX_TERMS) begin
      second_terms[second_len] = t;
      second_len++;
    end else begin
      drop_seen = 1'b1;
    end
    if (!last) return;

    m.final_term = 1'b0;
    m.dropped    = drop_seen;
    while (i < first_len || j < second_len) begin
      ea = (i < first_len)  ? $signed(first_terms[i].exp)  : '0;
      eb = (j < second_len) ? $signed(second_terms[j].exp) : '0;
      ca = (i < first_len)  ? spm_pkg::SUM_W'(first_terms[i].coeff)  : '0;
      cb = (j < second_len) ? spm_pkg::SUM_W'(second_terms[j].coeff) : '0;
      if (j >= second_len || (i < first_len && ea > eb)) begin
        m.coeff = ca;
        m.exp   = ea;
        i++;
      end else if (i >= first_len || ea < eb) begin
        m.coeff = cb;
        m.exp   = eb;
        j++;
      end else begin
        m.coeff = ca + cb;
        m.exp   = ea;
        i++;
        j++;
      end
      expected_terms.push_back(m);
    end
    expected_terms[expected_terms.size()-1].final_term = 1'b1;
    merges_seen++;
    if (drop_seen) overflow_merges++;
    first_len  = 0;
    second_len = 0;
    drop_seen  = 1'b0;
  endfunction

  always @(posedge clk_i) begin : monitor
    merged_term_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        load_term(s_axis_tuser, {s_axis_tdata[31:0], s_axis_tdata[47:32]}, s_axis_tlast);
        terms_loaded++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_terms.size() == 0) begin
          $error("merged term with nothing expected: coeff %0d exponent %0d",
                 $signed(m_axis_tdata[32:0]), $signed(m_axis_tdata[48:33]));
          errors++;
        end else begin
          want = expected_terms.pop_front();
          terms_checked++;
          if (m_axis_tdata[32:0] !== want.coeff) begin
            $error("out_coeff: expected %0d, got %0d", want.coeff,
                   $signed(m_axis_tdata[32:0]));
            errors++;
          end
          if (m_axis_tdata[48:33] !== want.exp) begin
            $error("out_exponent: expected %0d, got %0d", want.exp,
                   $signed(m_axis_tdata[48:33]));
            errors++;
          end
          if (m_axis_tlast !== want.final_term) begin
            $error("final_term: expected %0b, got %0b", want.final_term, m_axis_tlast);
            errors++;
          end
          if (m_axis_tuser !== want.dropped) begin
            $error("overflow: expected %0b, got %0b", want.dropped, m_axis_tuser);
            errors++;
          end
        end
      end
    end
  end

  // called and returning at a falling edge
  task automatic send_term(input logic which, input spm_pkg::term_t t, input logic last);
    while (!calm && $urandom_range(99) < 7) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {t.exp, t.coeff};
    s_axis_tuser  <= which;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    int unsigned waited;
    waited = 0;
    s_axis_tvalid <= 1'b0;
    while (expected_terms.size() != 0 && waited < 20000) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (6) @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick_coeff();
    case ($urandom_range(3))
      0:       return 32'($urandom_range(0, 20)) - 32'd10;
      1:       return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  // one pair of polynomials, terms of both lists interleaved at random;
  // sorted pairs share some exponents so that sums occur
  task automatic run_pair(input int n1, input int n2, input bit sorted, input bit mark_noise);
    spm_pkg::term_t a[$];
    spm_pkg::term_t b[$];
    spm_pkg::term_t t;
    int    step_max;
    int    span;
    int    cur;
    int    pick;
    int    ia;
    int    ib;
    if (sorted) begin
      case ($urandom_range(3))
        0:       step_max = 1;
        1:       step_max = 4;
        2:       step_max = 300;
        default: step_max = 3000;
      endcase
      if (step_max * (n1 + n2) > 65535) step_max = 65535 / (n1 + n2);
      span = step_max * (n1 + n2);
      cur  = -32768 + span + $urandom_range(0, 65535 - span);
      while (a.size() < n1 || b.size() < n2) begin
        cur    -= $urandom_range(1, step_max);
        t.exp   = cur[15:0];
        t.coeff = pick_coeff();
        pick    = $urandom_range(2);
        if (a.size() == n1) pick = 1;
        else if (b.size() == n2) pick = 0;
        if (pick == 0) begin
          a.push_back(t);
        end else if (pick == 1) begin
          b.push_back(t);
        end else begin
          a.push_back(t);
          t.coeff = ($urandom_range(3) == 0) ? -t.coeff : pick_coeff();
          b.push_back(t);
        end
      end
    end else begin
      repeat (n1 + n2) begin
        t.coeff = pick_coeff();
        t.exp   = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(0, 15) - 8);
        if (a.size() < n1) a.push_back(t);
        else b.push_back(t);
      end
    end
    ia = 0;
    ib = 0;
    while (ia < a.size() || ib < b.size() - 1) begin
      if (ib >= b.size() - 1 || (ia < a.size() && $urandom_range(1))) begin
        send_term(1'b0, a[ia], mark_noise ? ($urandom_range(3) == 0) : (ia == a.size() - 1));
        ia++;
      end else begin
        send_term(1'b1, b[ib], 1'b0);
        ib++;
      end
    end
    send_term(1'b1, b[b.size()-1], 1'b1);
  endtask

  task automatic test_second_only();
    send_term(1'b1, '{32'h8000_0000, 16'h8000}, 1'b1);
    wait_idle();
  endtask

  // widest sums both ways and a sum that cancels to zero
  task automatic test_equal_exponents();
    send_term(1'b0, '{32'h7fff_ffff, 16'h7fff}, 1'b0);
    send_term(1'b1, '{32'h7fff_ffff, 16'h7fff}, 1'b0);
    send_term(1'b0, '{32'h8000_0000, 16'h0000}, 1'b0);
    send_term(1'b0, '{32'd5, 16'h8000}, 1'b1);
    send_term(1'b1, '{32'h8000_0000, 16'h0000}, 1'b0);
    send_term(1'b1, '{-32'sd5, 16'h8000}, 1'b1);
    wait_idle();
  endtask

  // tails of each list copied through; a first-list end mark that is not final
  task automatic test_tails();
    send_term(1'b0, '{32'd11, 16'd100}, 1'b0);
    send_term(1'b0, '{32'd12, 16'd50}, 1'b0);
    send_term(1'b0, '{32'd13, 16'd10}, 1'b1);
    send_term(1'b1, '{32'd14, 16'd200}, 1'b1);
    wait_idle();
    send_term(1'b0, '{32'd21, 16'd300}, 1'b1);
    send_term(1'b1, '{32'd22, 16'd20}, 1'b0);
    send_term(1'b1, '{32'd23, 16'd10}, 1'b0);
    send_term(1'b1, '{-32'sd24, -16'sd5}, 1'b1);
    wait_idle();
    send_term(1'b0, '{32'd31, 16'd40}, 1'b1);
    send_term(1'b0, '{32'd32, 16'd30}, 1'b0);
    send_term(1'b1, '{32'd33, 16'd35}, 1'b1);
    wait_idle();
  endtask

  task automatic test_unsorted();
    send_term(1'b0, '{32'd1, 16'd1}, 1'b0);
    send_term(1'b0, '{32'd2, 16'd5}, 1'b0);
    send_term(1'b0, '{32'd3, 16'd3}, 1'b1);
    send_term(1'b1, '{32'd4, 16'd4}, 1'b0);
    send_term(1'b1, '{32'd5, 16'd2}, 1'b0);
    send_term(1'b1, '{32'd6, 16'd6}, 1'b1);
    wait_idle();
  endtask

  // overfull lists (the dropped closing term still starts the merge), then exactly full
  task automatic test_list_full();
    run_pair(34, 33, 1'b1, 1'b0);
    wait_idle();
    run_pair(33, 2, 1'b1, 1'b0);
    wait_idle();
    run_pair(32, 32, 1'b1, 1'b0);
    wait_idle();
  endtask

  task automatic test_random();
    int unsigned start;
    int unsigned r;
    start = items_sent;
    while (items_sent - start < 240) begin
      calm = (items_sent - start >= 80) && (items_sent - start < 170);
      r    = $urandom_range(99);
      if (r < 6) run_pair($urandom_range(20, 32), $urandom_range(20, 32), 1'b1, 1'b0);
      else if (r < 76) run_pair($urandom_range(0, 6), $urandom_range(1, 6), 1'b1, 1'b0);
      else if (r < 92) run_pair($urandom_range(0, 6), $urandom_range(1, 6), 1'b0, 1'b0);
      else run_pair($urandom_range(0, 6), $urandom_range(1, 6), $urandom_range(1), 1'b1);
    end
    calm = 1'b0;
    wait_idle();
  endtask

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    calm          = 1'b0;
    first_len     = 0;
    second_len    = 0;
    drop_seen     = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_second_only();
    test_equal_exponents();
    test_tails();
    test_unsorted();
    test_list_full();
    test_random();

    if (expected_terms.size() != 0) begin
      $error("%0d merged terms never arrived", expected_terms.size());
      errors++;
    end
    $display("loaded %0d terms in %0d merges (%0d with dropped terms)",
             terms_loaded, merges_seen, overflow_merges);
    $display("checked %0d merged terms, %0d mismatches", terms_checked, errors);
    if (errors == 0) begin
      $display("sparse_polynomial_merge_add verification clean");
    end else begin
      $display("sparse_polynomial_merge_add verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("sparse_polynomial_merge_add verification failed");
    $finish;
  end

endmodule

// File: sparse_polynomial_merge_add.f
rtl/spm_pkg.sv
rtl/spm_store.sv
rtl/spm_pick.sv
rtl/sparse_polynomial_merge_add.sv
test/testbench.sv
